/* design/pli_pkg.sv */
// ----------------------------------------------------------------------------
// pli_pkg
// shared constants and codes for the piecewise linear interpolator
// ----------------------------------------------------------------------------
package pli_pkg;
    localparam int TABLE_DEPTH_DEF = 64;
    localparam int VAL_W = 32;

    typedef enum logic [1:0] {
        ST_VALID  = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2,
        ST_STORED = 2'd3
    } t_status;

    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_EVAL = 1'b1;
endpackage

/* design/pli_div.sv */
// ----------------------------------------------------------------------------
// pli_div
// serial signed divide, 64-bit numerator by positive 33-bit divisor,
// one quotient bit per cycle, truncating toward zero
// ----------------------------------------------------------------------------
module pli_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_num,
    input  logic        [32:0] i_den,
    output logic               o_done,
    output logic signed [31:0] o_quot
);
    import pli_pkg::*;

    logic [63:0] r_q, n_q;
    logic [33:0] r_rem, n_rem;
    logic [32:0] r_den;
    logic [6:0]  r_cnt;
    logic        r_neg, r_busy, r_done;
    logic [33:0] w_try;
    logic [63:0] w_neg_q;

    assign w_try   = {r_rem[32:0], r_q[63]} - {1'b0, r_den};
    assign w_neg_q = -r_q;
    assign o_done  = r_done;
    assign o_quot  = r_neg ? w_neg_q[VAL_W-1:0] : r_q[VAL_W-1:0];

    // one restoring step per cycle
    always_comb begin
        n_rem = {r_rem[32:0], r_q[63]};
        n_q   = {r_q[62:0], 1'b0};
        if (!w_try[33]) begin
            n_rem = w_try;
            n_q[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 7'd0;
            r_rem  <= '0;
            r_q    <= i_num[63] ? -i_num : i_num;
            r_neg  <= i_num[63];
            r_den  <= i_den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= n_q;
            r_cnt <= r_cnt + 7'd1;
            if (r_cnt == 7'd63) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end
endmodule

/* design/piecewise_linear_interpolator.sv */
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator
// sorted breakpoint table with linear interpolation between neighbors
// ----------------------------------------------------------------------------
// Input stream: s_axis, tuser = kind (0 add, 1 evaluate), tdata = point_x
// then point_y. Output stream: m_axis, tdata = result_value then status.
// Items are handled one at a time. The table sits in two single-port
// memories (key and value), one read per cycle with registered data.
// Add: a linear scan checks one key at a time up to the insert
// point, then the tail is shifted up one entry at a time (read,
// wait, write) and the new entry is written in.
// A full table add or an evaluate on an empty table skips the table.
// Evaluate: the same scan, then a clamped result returns an end entry;
// interpolation reads both neighbors, multiplies and runs a serial divide.
// The next item can be taken in the same cycle that the result appears.
// Reset clears the count, state and output valid; memory needs no clearing.
// While the receiver stalls the result waits in the output register; the
// next item is still taken and waits at its end until that register frees.
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator #(
    parameter int TABLE_DEPTH = pli_pkg::TABLE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // point_x [31:0], point_y [63:32]
    input  logic        s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // result_value [31:0], status [33:32], zero fill
);
    import pli_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_SCANW, S_SHR, S_SHW, S_INS,
        S_RDL, S_RDU, S_MUL, S_SUM, S_DIV, S_OUT
    } t_state;

    t_state r_state;
    logic signed [31:0] r_keys [TABLE_DEPTH];
    logic signed [31:0] r_vals [TABLE_DEPTH];
    logic signed [31:0] r_kd, r_vd;
    logic [CW-1:0] r_cnt, r_idx, r_pos;
    logic signed [31:0] r_x, r_y, r_xl, r_yl, r_res;
    logic signed [31:0] r_ores;
    logic [1:0]  r_ostat;
    logic        r_kind, r_ovalid, r_rd_en;
    logic [1:0]  r_stat;
    logic [AW-1:0] r_rd_a;
    logic        r_wr_en;
    logic [AW-1:0] r_wr_a;
    logic signed [31:0] r_wk, r_wv;
    logic signed [64:0] r_p1, r_p2;
    logic signed [63:0] r_num;
    logic [32:0] r_den;
    logic        r_dstart;
    logic        w_ddone;
    logic signed [31:0] w_quot;
    logic signed [32:0] w_dx1, w_dx2;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {6'd0, r_ostat, r_ores};

    // table memories, one port each, registered read
    always_ff @(posedge i_clk) begin
        if (r_wr_en) begin
            r_keys[r_wr_a] <= r_wk;
            r_vals[r_wr_a] <= r_wv;
        end
        if (r_rd_en) begin
            r_kd <= r_keys[r_rd_a];
            r_vd <= r_vals[r_rd_a];
        end
    end

    pli_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_dstart),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (w_ddone),
        .o_quot  (w_quot)
    );

    assign w_dx1 = {r_x[31], r_x} - {r_xl[31], r_xl};
    assign w_dx2 = {r_kd[31], r_kd} - {r_x[31], r_x};

    // sequencer
    always_ff @(posedge i_clk) begin
        r_wr_en  <= 1'b0;
        r_rd_en  <= 1'b0;
        r_dstart <= 1'b0;
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && m_axis_tready && r_state != S_OUT) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_kind <= s_axis_tuser;
                        r_x    <= s_axis_tdata[31:0];
                        r_y    <= s_axis_tdata[63:32];
                        r_idx  <= '0;
                        r_res  <= '0;
                        if (s_axis_tuser == KIND_ADD && r_cnt == DEPTH_C) begin
                            r_stat <= ST_FULL;
                            r_state <= S_OUT;
                        end else if (s_axis_tuser == KIND_EVAL && r_cnt == '0) begin
                            r_stat <= ST_EMPTY;
                            r_state <= S_OUT;
                        end else if (r_cnt == '0) begin
                            r_pos <= '0;
                            r_state <= S_INS;
                        end else begin
                            r_rd_en <= 1'b1;
                            r_rd_a  <= '0;
                            r_state <= S_SCANW;
                        end
                    end
                end
                S_SCANW: r_state <= S_SCAN;
                S_SCAN: begin
                    // r_kd holds key at r_idx
                    if (r_kd > r_x) begin
                        r_pos <= r_idx;
                        r_state <= (r_kind == KIND_ADD) ? S_SHR : S_RDL;
                        if (r_kind == KIND_ADD) r_idx <= r_cnt;
                    end else if (r_idx + 1'b1 == r_cnt) begin
                        r_pos <= r_cnt;
                        r_state <= (r_kind == KIND_ADD) ? S_SHR : S_RDL;
                        if (r_kind == KIND_ADD) r_idx <= r_cnt;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_rd_en <= 1'b1;
                        r_rd_a  <= AW'(r_idx + 1'b1);
                        r_state <= S_SCANW;
                    end
                end
                S_SHR: begin
                    // move entry idx-1 to idx, from the top down
                    if (r_idx == r_pos) begin
                        r_state <= S_INS;
                    end else begin
                        r_rd_en <= 1'b1;
                        r_rd_a  <= AW'(r_idx - 1'b1);
                        r_state <= S_SHW;
                    end
                end
                S_SHW: begin
                    if (!r_rd_en) begin
                        r_wr_en <= 1'b1;
                        r_wr_a  <= AW'(r_idx);
                        r_wk    <= r_kd;
                        r_wv    <= r_vd;
                        r_idx   <= r_idx - 1'b1;
                        r_state <= S_SHR;
                    end
                end
                S_INS: begin
                    r_wr_en <= 1'b1;
                    r_wr_a  <= AW'(r_pos);
                    r_wk    <= r_x;
                    r_wv    <= r_y;
                    r_cnt   <= r_cnt + 1'b1;
                    r_stat  <= ST_STORED;
                    r_state <= S_OUT;
                end
                S_RDL: begin
                    // fetch the lower neighbor, or the clamp entry
                    r_rd_en <= 1'b1;
                    r_stat  <= ST_VALID;
                    if (r_pos == '0) r_rd_a <= '0;
                    else r_rd_a <= AW'(r_pos - 1'b1);
                    r_idx <= '0;
                    r_state <= S_RDU;
                end
                S_RDU: begin
                    if (r_idx == '0) begin
                        r_idx <= CW'(1);
                    end else if (r_idx == CW'(1)) begin
                        r_xl <= r_kd;
                        r_yl <= r_vd;
                        if (r_pos == '0 || r_pos == r_cnt) begin
                            r_res <= r_vd;
                            r_state <= S_OUT;
                        end else begin
                            r_rd_en <= 1'b1;
                            r_rd_a  <= AW'(r_pos);
                            r_idx   <= CW'(2);
                        end
                    end else if (r_idx == CW'(2)) begin
                        r_idx <= CW'(3);
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_p1  <= w_dx1 * r_vd;
                    r_p2  <= w_dx2 * r_yl;
                    r_den <= 33'({r_kd[31], r_kd} - {r_xl[31], r_xl});
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_num    <= 64'(r_p1 + r_p2);
                    r_dstart <= 1'b1;
                    r_state  <= S_DIV;
                end
                S_DIV: begin
                    if (w_ddone) begin
                        r_res <= w_quot;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // hand over once the output register is free
                    if (!r_ovalid || m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_ores   <= r_res;
                        r_ostat  <= r_stat;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // checks on the sequencer
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= DEPTH_C) else $error("entry count beyond depth");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !m_axis_tready) |=> (r_ovalid && $stable(m_axis_tdata)))
        else $error("held result changed");
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != $past(r_cnt)) |-> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("count moved by other than one");
    a_res_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_ostat != ST_VALID) |-> (r_ores == '0))
        else $error("nonzero value on non-valid status");
endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// checks the breakpoint table and interpolation of piecewise_linear_interpolator
// against an in-bench table model, with directed and random traffic and
// random idle bursts on both stream sides
// ----------------------------------------------------------------------------
module tb_top;
    import pli_pkg::*;

    localparam int DEPTH = TABLE_DEPTH_DEF;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [31:0] value;
        t_status     status;
    } t_answer;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // point_x [31:0], point_y [63:32]
    logic        s_axis_tuser;   // kind
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // result_value [31:0], status [33:32], zero fill

    // table model
    logic signed [31:0] tbl_key [DEPTH];
    logic signed [31:0] tbl_val [DEPTH];
    int                 tbl_count;
    t_answer            answer_queue [$];
    int                 error_count;
    int                 idle_cycles;
    bit                 quiet_tail;

    piecewise_linear_interpolator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    // index of first key strictly above x
    function automatic int first_key_above(logic signed [31:0] x);
        int i;
        i = 0;
        while (i < tbl_count && tbl_key[i] <= x) i++;
        return i;
    endfunction

    // update the table and work out the answer for one item
    function automatic t_answer table_apply(logic kind, logic signed [31:0] x,
                                            logic signed [31:0] y);
        t_answer            ans;
        int                 up;
        logic signed [63:0] xl, xu, yl, yu, num, den;
        ans.value = '0;
        if (kind == KIND_ADD) begin
            if (tbl_count >= DEPTH) begin
                ans.status = ST_FULL;
            end else begin
                up = first_key_above(x);
                for (int i = tbl_count; i > up; i--) begin
                    tbl_key[i] = tbl_key[i-1];
                    tbl_val[i] = tbl_val[i-1];
                end
                tbl_key[up] = x;
                tbl_val[up] = y;
                tbl_count++;
                ans.status = ST_STORED;
            end
        end else if (tbl_count == 0) begin
            ans.status = ST_EMPTY;
        end else begin
            ans.status = ST_VALID;
            up = first_key_above(x);
            if (up == 0) begin
                ans.value = tbl_val[0];
            end else if (up >= tbl_count) begin
                ans.value = tbl_val[tbl_count-1];
            end else begin
                xl = tbl_key[up-1];
                xu = tbl_key[up];
                yl = tbl_val[up-1];
                yu = tbl_val[up];
                den = xu - xl;
                num = (64'(x) - xl) * yu + (xu - 64'(x)) * yl;
                ans.value = 32'(num / den);
            end
        end
        return ans;
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch: %s", what);
        error_count++;
    endtask

    // one transfer into the block, with an optional idle burst first
    task automatic send_item(logic kind, logic [31:0] x, logic [31:0] y);
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {y, x};
        do @(posedge i_clk); while (!s_axis_tready);
        answer_queue.insert(answer_queue.size(), table_apply(kind, x, y));
        @(negedge i_clk);
    endtask

    // receiver stalls
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // result checker and watchdog
    always @(posedge i_clk) begin
        t_answer exp_ans;
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (m_axis_tvalid && m_axis_tready) begin
                if (answer_queue.size() == 0) begin
                    report_mismatch("result with nothing expected");
                end else begin
                    exp_ans = answer_queue.pop_front();
                    if (m_axis_tdata[33:32] != exp_ans.status)
                        report_mismatch($sformatf("status got %0d exp %0d",
                            m_axis_tdata[33:32], exp_ans.status));
                    if (m_axis_tdata[31:0] != exp_ans.value)
                        report_mismatch($sformatf("value got %h exp %h",
                            m_axis_tdata[31:0], exp_ans.value));
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'(int'($urandom_range(0, 64)) - 32) <<< 16;
            default: return $urandom();
        endcase
    endfunction

    task automatic test_empty_and_extremes();
        send_item(KIND_EVAL, 32'h0, 32'hffff_ffff);
        send_item(KIND_ADD, 32'h8000_0000, 32'h7fff_ffff);
        send_item(KIND_ADD, 32'h7fff_ffff, 32'h8000_0000);
        send_item(KIND_EVAL, 32'h8000_0000, 32'h0);
        send_item(KIND_EVAL, 32'h0, 32'h0);
        send_item(KIND_EVAL, 32'h7fff_fffe, 32'h0);
        send_item(KIND_EVAL, 32'h7fff_ffff, 32'h0);
        // duplicate key keeps insertion order
        send_item(KIND_ADD, 32'h0001_0000, 32'h0000_5000);
        send_item(KIND_ADD, 32'h0001_0000, 32'hffff_0000);
        send_item(KIND_EVAL, 32'h0001_0000, 32'h0);
        send_item(KIND_EVAL, 32'h0000_ffff, 32'h0);
    endtask

    task automatic test_fill_table();
        while (tbl_count < DEPTH)
            send_item(KIND_ADD, rand_word(), rand_word());
        send_item(KIND_ADD, 32'h0, 32'h1234_5678);
        send_item(KIND_ADD, 32'hffff_ffff, 32'hffff_ffff);
        for (int i = 0; i < 8; i++) send_item(KIND_EVAL, rand_word(), rand_word());
    endtask

    // later tables live behind fresh queries only; the block has no clear
    task automatic test_random_traffic(int count);
        for (int i = 0; i < count; i++)
            send_item($urandom_range(0, 9) < 2 ? KIND_ADD : KIND_EVAL,
                      rand_word(), rand_word());
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser = 1'b0;
        s_axis_tdata = '0;
        tbl_count = 0;
        error_count = 0;
        idle_cycles = 0;
        quiet_tail = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_empty_and_extremes();
        test_fill_table();
        test_random_traffic(1100);
        quiet_tail = 1'b1;
        test_random_traffic(250);
        s_axis_tvalid <= 1'b0;
        while (answer_queue.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
